FILE: design/ced_pkg.sv
// Shared constants and types for the compass edge detector.
package ced_pkg;

   // Item codes carried on the action field.
   localparam logic ACTION_PUSH  = 1'b0;
   localparam logic ACTION_FLUSH = 1'b1;

   // Configuration register indexes.
   localparam logic [2:0] CSR_IMAGE_WIDTH    = 3'd0;
   localparam logic [2:0] CSR_IMAGE_HEIGHT   = 3'd1;
   localparam logic [2:0] CSR_GRADIENT_SHIFT = 3'd2;
   localparam logic [2:0] CSR_THRESH_LOW     = 3'd3;
   localparam logic [2:0] CSR_THRESH_HIGH    = 3'd4;
   localparam logic [2:0] CSR_MAX_LEVEL      = 3'd5;

   // Configuration reset values.
   localparam logic [12:0] WIDTH_RESET     = 13'd640;
   localparam logic [15:0] HEIGHT_RESET    = 16'd480;
   localparam logic [4:0]  SHIFT_RESET     = 5'd0;
   localparam logic [15:0] THRESH_LO_RESET = 16'd0;
   localparam logic [15:0] THRESH_HI_RESET = 16'd65535;
   localparam logic [15:0] MAX_LEVEL_RESET = 16'd255;

   // Output queue sizing.
   localparam int OUT_DEPTH = 16;
   localparam int OUT_PTR_W = 4;
   localparam int OUT_CNT_W = 5;

   // Compass masks over window index (row*3+col): first five add, last three subtract.
   localparam logic [3:0] MASK_TAB [0:7][0:7] = '{
      '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd8},
      '{4'd0, 4'd1, 4'd2, 4'd3, 4'd6, 4'd5, 4'd7, 4'd8},
      '{4'd0, 4'd1, 4'd3, 4'd6, 4'd7, 4'd2, 4'd5, 4'd8},
      '{4'd0, 4'd3, 4'd6, 4'd7, 4'd8, 4'd1, 4'd2, 4'd5},
      '{4'd3, 4'd5, 4'd6, 4'd7, 4'd8, 4'd0, 4'd1, 4'd2},
      '{4'd2, 4'd5, 4'd6, 4'd7, 4'd8, 4'd0, 4'd1, 4'd3},
      '{4'd1, 4'd2, 4'd5, 4'd7, 4'd8, 4'd0, 4'd3, 4'd6},
      '{4'd0, 4'd1, 4'd2, 4'd5, 4'd8, 4'd3, 4'd6, 4'd7}
   };

   // Control of the item in the line store read stage.
   typedef struct packed {
      logic valid;
      logic flush;
      logic bank;
      logic mirror_top;
      logic c_one;
      logic emit_a;
      logic emit_b;
      logic l_mirror;
      logic r_mirror;
      logic last;
   } s1_ctrl_type;

endpackage

FILE: design/ced_ram.sv
// Generic single-clock RAM: one write port, one registered read port, read-first.
module ced_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/compass_edge_detector_3x3.sv
// Top level of the 3x3 compass edge detector over a raster pixel stream.
//
// Pixels enter in raster order, one item per clock while req_stall is low; the
// first flush item of a frame is held while column 0 of the last two rows is
// read from the line store. Two line store banks (even and odd rows, MAX_WIDTH
// deep each) are read at the current column (a flush reads the next one) and a
// push writes its pixel in the same cycle, so a single read and a single write
// port per bank set the rate. Output runs one row behind the input; the last
// pixel of a row gives two results, and flush items give the final row.
// Results leave through a 16-item queue; req_stall also rises when the queue
// space reserved by items in flight leaves no room for two more results.
// Borders mirror without repeating the edge pixel. Entries of the line store
// that were never written read as undefined; no clearing pass is done.
module compass_edge_detector_3x3 #(
   parameter int MAX_WIDTH  = 4096,
   parameter int PIXEL_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [15:0] req_pixel,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_edge_value,
   output logic        rsp_frame_last,
   // configuration writes
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   import ced_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WX    = (COL_W + 1 > 13) ? COL_W + 1 : 13;
   localparam int SW    = PIXEL_BITS + 4;          // signed compass sum
   localparam int MW    = PIXEL_BITS + 3;          // magnitude
   localparam int VW    = (MW > 16) ? MW : 16;     // threshold compare width

   typedef logic [PIXEL_BITS-1:0] pix_type;

   // ---------------------------------------------------------------- config
   logic [12:0] csr_width_ff;
   logic [15:0] csr_height_ff;
   logic [4:0]  csr_shift_ff;
   logic [15:0] csr_tlow_ff;
   logic [15:0] csr_thigh_ff;
   logic [15:0] csr_maxlev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_width_ff  <= WIDTH_RESET;
         csr_height_ff <= HEIGHT_RESET;
         csr_shift_ff  <= SHIFT_RESET;
         csr_tlow_ff   <= THRESH_LO_RESET;
         csr_thigh_ff  <= THRESH_HI_RESET;
         csr_maxlev_ff <= MAX_LEVEL_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:    csr_width_ff  <= csr_data[12:0];
            CSR_IMAGE_HEIGHT:   csr_height_ff <= csr_data;
            CSR_GRADIENT_SHIFT: csr_shift_ff  <= csr_data[4:0];
            CSR_THRESH_LOW:     csr_tlow_ff   <= csr_data;
            CSR_THRESH_HIGH:    csr_thigh_ff  <= csr_data;
            CSR_MAX_LEVEL:      csr_maxlev_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Effective last column (width clamped to 2..MAX_WIDTH) and height (at least 2).
   logic [WX-1:0]    width_ext;
   logic [COL_W-1:0] w_last;
   logic [15:0]      h_eff;

   always_comb begin
      width_ext = WX'(csr_width_ff);
      if (width_ext < WX'(2)) begin
         w_last = COL_W'(1);
      end else if (width_ext >= WX'(MAX_WIDTH)) begin
         w_last = COL_W'(MAX_WIDTH - 1);
      end else begin
         w_last = COL_W'(width_ext - WX'(1));
      end
      h_eff = (csr_height_ff < 16'd2) ? 16'd2 : csr_height_ff;
   end

   // ---------------------------------------------------------------- accept stage
   logic [COL_W-1:0]     col_ff, col_in;
   logic [15:0]          row_ff, row_in;
   logic                 pre_ff, pre_in;      // column 0 of the flush rows fetched
   logic                 cap_ff;              // fetched column arrives this cycle
   logic [OUT_CNT_W-1:0] pend_ff, pend_in;    // results reserved, not yet delivered

   logic       req_accept, is_flush, in_frame, col_at_end, need_pre;
   logic       do_push, do_flush, emit_a, emit_b;
   logic       rsp_pop;
   logic [COL_W-1:0] rd_addr;
   logic [PIXEL_BITS-1:0] pix_masked;
   s1_ctrl_type s1_in, s1_ff;

   assign is_flush   = (req_action == ACTION_FLUSH);
   assign in_frame   = (row_ff < h_eff);
   assign col_at_end = (col_ff >= w_last);
   // Hold the first flush of a frame while column 0 is fetched.
   assign need_pre   = req_valid && is_flush && !in_frame && (col_ff == '0) && !pre_ff;
   assign req_stall  = need_pre || (pend_ff > OUT_CNT_W'(OUT_DEPTH - 2));
   assign req_accept = req_valid && !req_stall;
   assign do_push    = req_accept && !is_flush && in_frame;
   assign do_flush   = req_accept && is_flush && !in_frame;
   assign emit_a     = do_flush || (do_push && (row_ff != '0) && (col_ff != '0));
   assign emit_b     = do_push && col_at_end && (row_ff != '0);
   assign pix_masked = req_pixel[PIXEL_BITS-1:0];
   assign rsp_pop    = rsp_valid && !rsp_stall;

   always_comb begin
      // Both banks read the same column: the fetch reads column 0, a push its own
      // column, a flush the next one to the right.
      if (need_pre) begin
         rd_addr = '0;
      end else if (is_flush) begin
         rd_addr = COL_W'(col_ff + COL_W'(1));
      end else begin
         rd_addr = col_ff;
      end

      col_in = col_ff;
      row_in = row_ff;
      if (do_push) begin
         if (col_at_end) begin
            col_in = '0;
            row_in = row_ff + 16'd1;
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end else if (do_flush) begin
         if (col_at_end) begin
            col_in = '0;
            row_in = '0;
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end

      pre_in = pre_ff;
      if (need_pre) begin
         pre_in = 1'b1;
      end else if (do_push || do_flush) begin
         pre_in = 1'b0;
      end

      pend_in = pend_ff + OUT_CNT_W'(emit_a) + OUT_CNT_W'(emit_b) - OUT_CNT_W'(rsp_pop);

      s1_in.valid      = do_push || do_flush;
      s1_in.flush      = do_flush;
      s1_in.bank       = row_ff[0];
      s1_in.mirror_top = (row_ff == 16'd1);
      s1_in.c_one      = (col_ff == COL_W'(1));
      s1_in.emit_a     = emit_a;
      s1_in.emit_b     = emit_b;
      s1_in.l_mirror   = (col_ff == '0);
      s1_in.r_mirror   = col_at_end;
      s1_in.last       = do_flush && col_at_end;
   end

   // ---------------------------------------------------------------- line store
   pix_type rd_data0, rd_data1;

   ced_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_bank0 (
      .clock   (clock),
      .wr_en   (do_push && !row_ff[0]),
      .wr_addr (col_ff),
      .wr_data (pix_masked),
      .rd_addr (rd_addr),
      .rd_data (rd_data0)
   );

   ced_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_bank1 (
      .clock   (clock),
      .wr_en   (do_push && row_ff[0]),
      .wr_addr (col_ff),
      .wr_data (pix_masked),
      .rd_addr (rd_addr),
      .rd_data (rd_data1)
   );

   // ---------------------------------------------------------------- window stage
   pix_type s1_pix_ff;
   pix_type win_ff [3][3];          // [row][col], row 0 oldest, col 2 newest
   pix_type win_in [3][3];
   pix_type fw_top_prev_ff, fw_top_cur_ff, fw_mid_prev_ff, fw_mid_cur_ff;
   pix_type top_d, mid_d, cap_top, cap_mid, lt, rt, lm, rm;
   pix_type lane_in [2][9];
   pix_type lane_ff [2][9];
   logic [1:0] lane_v_ff;
   logic       lane_last_ff;

   always_comb begin
      logic [1:0] src;
      // Older row sits in the bank of the current row parity.
      top_d   = s1_ff.bank ? rd_data1 : rd_data0;
      mid_d   = s1_ff.bank ? rd_data0 : rd_data1;
      cap_top = row_ff[0] ? rd_data1 : rd_data0;
      cap_mid = row_ff[0] ? rd_data0 : rd_data1;

      win_in = win_ff;
      if (s1_ff.valid && !s1_ff.flush) begin
         for (int k = 0; k < 3; k++) begin
            win_in[k][0] = win_ff[k][1];
            win_in[k][1] = win_ff[k][2];
         end
         win_in[0][2] = top_d;
         win_in[1][2] = mid_d;
         win_in[2][2] = s1_pix_ff;
      end
      if (s1_ff.valid && s1_ff.last) begin
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               win_in[k][j] = '0;
            end
         end
      end

      lt = s1_ff.l_mirror ? top_d : fw_top_prev_ff;
      lm = s1_ff.l_mirror ? mid_d : fw_mid_prev_ff;
      rt = s1_ff.r_mirror ? fw_top_prev_ff : top_d;
      rm = s1_ff.r_mirror ? fw_mid_prev_ff : mid_d;

      for (int k = 0; k < 3; k++) begin
         src = (k == 0 && s1_ff.mirror_top) ? 2'd2 : 2'(k);
         if (s1_ff.flush) begin
            // Last row: the row below mirrors onto the row above.
            lane_in[0][k*3+0] = (k == 1) ? lm : lt;
            lane_in[0][k*3+1] = (k == 1) ? fw_mid_cur_ff : fw_top_cur_ff;
            lane_in[0][k*3+2] = (k == 1) ? rm : rt;
         end else begin
            lane_in[0][k*3+0] = win_in[src][s1_ff.c_one ? 2 : 0];
            lane_in[0][k*3+1] = win_in[src][1];
            lane_in[0][k*3+2] = win_in[src][2];
         end
         // Right border of the row: column W mirrors onto column W-2.
         lane_in[1][k*3+0] = win_in[src][1];
         lane_in[1][k*3+1] = win_in[src][2];
         lane_in[1][k*3+2] = win_in[src][1];
      end
   end

   // ---------------------------------------------------------------- evaluation
   function automatic logic signed [SW-1:0] compass_sum(input pix_type v [9], input int m);
      logic signed [SW-1:0] acc;
      logic signed [SW-1:0] term;
      acc = '0;
      for (int j = 0; j < 8; j++) begin
         term = SW'(v[MASK_TAB[m][j]]);
         if (j < 5) begin
            acc = acc + term;
         end else begin
            acc = acc - term;
         end
      end
      return acc;
   endfunction

   logic signed [SW-1:0] sum_in [2][8];
   logic signed [SW-1:0] sum_ff [2][8];
   logic [1:0]           sum_v_ff;
   logic                 sum_last_ff;
   logic [MW-1:0]        best_in [2];
   logic [MW-1:0]        best_ff [2];
   logic [1:0]           best_v_ff;
   logic                 best_last_ff;
   logic [15:0]          res_val [2];

   always_comb begin
      logic [MW-1:0] mag;
      logic [VW-1:0] shifted, tmin, tmax, val;
      for (int l = 0; l < 2; l++) begin
         for (int m = 0; m < 8; m++) begin
            sum_in[l][m] = compass_sum(lane_ff[l], m);
         end
         best_in[l] = '0;
         for (int m = 0; m < 8; m++) begin
            mag = sum_ff[l][m][SW-1] ? MW'(-sum_ff[l][m]) : MW'(sum_ff[l][m]);
            if (mag > best_in[l]) begin
               best_in[l] = mag;
            end
         end
      end

      // Clamp thresholds to the max level; the low test wins over the high one.
      tmin = VW'((csr_tlow_ff < csr_maxlev_ff) ? csr_tlow_ff : csr_maxlev_ff);
      tmax = VW'((csr_thigh_ff < csr_maxlev_ff) ? csr_thigh_ff : csr_maxlev_ff);
      for (int l = 0; l < 2; l++) begin
         shifted = VW'(best_ff[l] >> csr_shift_ff);
         val     = shifted;
         if (val >= tmax) begin
            val = VW'(csr_maxlev_ff);
         end
         if (val <= tmin) begin
            val = '0;
         end
         res_val[l] = val[15:0];
      end
   end

   // ---------------------------------------------------------------- output queue
   logic [15:0]          q_edge_ff [OUT_DEPTH];
   logic                 q_last_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] q_wp_ff, q_rp_ff, q_wp_in, q_rp_in;
   logic [OUT_CNT_W-1:0] q_cnt_ff, q_cnt_in;

   always_comb begin
      q_wp_in  = q_wp_ff + OUT_PTR_W'(best_v_ff[0]) + OUT_PTR_W'(best_v_ff[1]);
      q_rp_in  = q_rp_ff + OUT_PTR_W'(rsp_pop);
      q_cnt_in = q_cnt_ff + OUT_CNT_W'(best_v_ff[0]) + OUT_CNT_W'(best_v_ff[1])
                 - OUT_CNT_W'(rsp_pop);
   end

   assign rsp_valid      = (q_cnt_ff != '0);
   assign rsp_edge_value = q_edge_ff[q_rp_ff];
   assign rsp_frame_last = q_last_ff[q_rp_ff];

   // ---------------------------------------------------------------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         pre_ff    <= 1'b0;
         cap_ff    <= 1'b0;
         pend_ff   <= '0;
         s1_ff     <= '0;
         lane_v_ff <= '0;
         sum_v_ff  <= '0;
         best_v_ff <= '0;
         q_wp_ff   <= '0;
         q_rp_ff   <= '0;
         q_cnt_ff  <= '0;
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[k][j] <= '0;
            end
         end
      end else begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         pre_ff    <= pre_in;
         cap_ff    <= need_pre;
         pend_ff   <= pend_in;
         s1_ff     <= s1_in;
         win_ff    <= win_in;
         lane_v_ff <= {s1_ff.valid && s1_ff.emit_b, s1_ff.valid && s1_ff.emit_a};
         sum_v_ff  <= lane_v_ff;
         best_v_ff <= sum_v_ff;
         q_wp_ff   <= q_wp_in;
         q_rp_ff   <= q_rp_in;
         q_cnt_ff  <= q_cnt_in;
      end
   end

   // ---------------------------------------------------------------- payload registers
   always_ff @(posedge clock) begin
      s1_pix_ff <= pix_masked;

      // Flush column window: load column 0 on the fetch, else advance per flush.
      if (cap_ff) begin
         fw_top_cur_ff <= cap_top;
         fw_mid_cur_ff <= cap_mid;
      end else if (s1_ff.valid && s1_ff.flush) begin
         fw_top_prev_ff <= fw_top_cur_ff;
         fw_mid_prev_ff <= fw_mid_cur_ff;
         fw_top_cur_ff  <= top_d;
         fw_mid_cur_ff  <= mid_d;
      end

      lane_ff      <= lane_in;
      lane_last_ff <= s1_ff.last;
      sum_ff       <= sum_in;
      sum_last_ff  <= lane_last_ff;
      best_ff      <= best_in;
      best_last_ff <= sum_last_ff;

      // Lane 1 only follows lane 0, so it takes the next slot.
      if (best_v_ff[0]) begin
         q_edge_ff[q_wp_ff] <= res_val[0];
         q_last_ff[q_wp_ff] <= best_last_ff;
      end
      if (best_v_ff[1]) begin
         q_edge_ff[OUT_PTR_W'(q_wp_ff + OUT_PTR_W'(1))] <= res_val[1];
         q_last_ff[OUT_PTR_W'(q_wp_ff + OUT_PTR_W'(1))] <= 1'b0;
      end
   end

   // ---------------------------------------------------------------- assertions
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= OUT_CNT_W'(OUT_DEPTH))
      else $error("reserved result count exceeds queue depth");

   a_queue_reserved: assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff <= pend_ff)
      else $error("queue holds more results than were reserved");

   a_lane_order: assert property (@(posedge clock) disable iff (reset)
      lane_v_ff[1] |-> lane_v_ff[0])
      else $error("row end result without its preceding result");

   a_fetch_alone: assert property (@(posedge clock) disable iff (reset)
      cap_ff |-> !s1_ff.valid)
      else $error("column fetch collides with an item in the window stage");

endmodule

FILE: bench/tb_compass_edge_detector_3x3.sv
// Self-checking bench for the compass edge detector: random frames, own predictor, result checks.
module tb_compass_edge_detector_3x3;
   import ced_pkg::*;

   localparam int MAX_W          = 4096;
   localparam int SETTLE_CYCLES  = 20;    // a few times the pipeline depth
   localparam int WATCHDOG_LIMIT = 3000;  // cycles with no item moving on either side
   localparam int REPORT_LIMIT   = 10;
   localparam int RANDOM_ITEMS   = 1400;

   // Outer ring of the 3x3 window in clockwise order, as row*3+col indexes.
   // Every compass mask adds five ring pixels and subtracts three consecutive
   // ones, so its sum is the ring sum minus twice that arc.
   localparam logic [7:0][3:0] RING = {4'd3, 4'd6, 4'd7, 4'd8, 4'd5, 4'd2, 4'd1, 4'd0};

   typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_mode_e;
   typedef enum int {PIX_FULL, PIX_RAILS, PIX_LOW, PIX_RAMP} pix_mode_e;

   typedef logic [8:0][15:0] win9_t;

   typedef struct {
      logic        action;
      logic [15:0] pixel;
      int          gap;     // idle cycles in front of this item
   } pix_item_t;

   typedef struct {
      logic [15:0] edge_value;
      logic        frame_last;
   } edge_result_t;

   // ---------------------------------------------------------------------------
   // Clock, reset and block ports
   // ---------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_action = ACTION_PUSH;
   logic [15:0] req_pixel = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_edge_value;
   logic        rsp_frame_last;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = CSR_IMAGE_WIDTH;
   logic [15:0] csr_data = '0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   compass_edge_detector_3x3 #(
      .MAX_WIDTH (MAX_W),
      .PIXEL_BITS(16)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_pixel     (req_pixel),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_edge_value(rsp_edge_value),
      .rsp_frame_last(rsp_frame_last),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   // ---------------------------------------------------------------------------
   // Bench state
   // ---------------------------------------------------------------------------
   pix_item_t    pixel_queue[$];     // items waiting for the driver
   edge_result_t pending_edges[$];   // edge results predicted, not yet seen

   idle_mode_e send_mode = IDLE_NONE;
   idle_mode_e rsp_mode  = IDLE_NONE;
   pix_mode_e  pix_mode  = PIX_FULL;

   int err_count     = 0;
   int push_count    = 0;
   int flush_count   = 0;
   int ignored_count = 0;
   int result_count  = 0;
   int frames_done   = 0;
   int csr_writes    = 0;

   // Predictor copy of the registers.
   logic [12:0] cfg_width = WIDTH_RESET;
   logic [15:0] cfg_height = HEIGHT_RESET;
   logic [4:0]  cfg_shift = SHIFT_RESET;
   logic [15:0] cfg_lo = THRESH_LO_RESET;
   logic [15:0] cfg_hi = THRESH_HI_RESET;
   logic [15:0] cfg_max = MAX_LEVEL_RESET;

   // Predictor copy of the datapath state.
   logic [15:0] line_mem [2*MAX_W];   // two banks: even rows, odd rows
   logic [15:0] win [3][3];           // [row][col], top row first
   int unsigned col_cnt = 0;
   int unsigned row_cnt = 0;

   // ---------------------------------------------------------------------------
   // Edge predictor
   // ---------------------------------------------------------------------------
   function automatic int unsigned eff_width();
      int unsigned w;
      w = cfg_width;
      if (w < 2) w = 2;
      if (w > MAX_W) w = MAX_W;
      return w;
   endfunction

   function automatic int unsigned eff_height();
      return (cfg_height < 2) ? 2 : cfg_height;
   endfunction

   // Row parity picks the bank; columns past the store saturate.
   function automatic int unsigned line_slot(int unsigned row, int unsigned col);
      if (col >= MAX_W) col = MAX_W - 1;
      return (row & 1) * MAX_W + col;
   endfunction

   function automatic logic [15:0] grad_eval(win9_t v);
      int ring_sum, arc, s, best, tmin, tmax, lvl;
      ring_sum = 0;
      best = 0;
      for (int i = 0; i < 8; i++) ring_sum += int'(v[RING[i]]);
      for (int i = 0; i < 8; i++) begin
         arc = int'(v[RING[i]]) + int'(v[RING[(i + 1) & 7]]) + int'(v[RING[(i + 2) & 7]]);
         s = ring_sum - 2 * arc;
         if (s < 0) s = -s;
         if (s > best) best = s;
      end
      best = best >> cfg_shift;
      lvl  = int'(cfg_max);
      tmin = (int'(cfg_lo) < lvl) ? int'(cfg_lo) : lvl;
      tmax = (int'(cfg_hi) < lvl) ? int'(cfg_hi) : lvl;
      // High test first: a result that clears both ends at zero.
      if (best >= tmax) best = lvl;
      if (best <= tmin) best = 0;
      return best[15:0];
   endfunction

   function automatic logic [15:0] win_eval(int lc, int mc, int rc, bit mirror_top);
      win9_t v;
      int    src;
      for (int k = 0; k < 3; k++) begin
         src = (k == 0 && mirror_top) ? 2 : k;
         v[k*3 + 0] = win[src][lc];
         v[k*3 + 1] = win[src][mc];
         v[k*3 + 2] = win[src][rc];
      end
      return grad_eval(v);
   endfunction

   function automatic void post_edge(logic [15:0] value, logic last);
      edge_result_t res;
      res.edge_value = value;
      res.frame_last = last;
      pending_edges.push_back(res);
   endfunction

   task automatic predict_edges(input logic act, input logic [15:0] pix);
      int unsigned w, h, c, r, lcol, rcol, top, mid;
      logic [15:0] older, prev;
      win9_t       v;
      w = eff_width();
      h = eff_height();
      c = col_cnt;
      r = row_cnt;
      if (act == ACTION_FLUSH) begin
         // Flush before every row is in: dropped without a result.
         if (r < h) begin
            ignored_count++;
            return;
         end
         flush_count++;
         lcol = (c == 0) ? 1 : c - 1;
         rcol = (c >= w - 1) ? c - 1 : c + 1;
         top  = r - 2;
         mid  = r - 1;
         v[0] = line_mem[line_slot(top, lcol)];
         v[1] = line_mem[line_slot(top, c)];
         v[2] = line_mem[line_slot(top, rcol)];
         v[3] = line_mem[line_slot(mid, lcol)];
         v[4] = line_mem[line_slot(mid, c)];
         v[5] = line_mem[line_slot(mid, rcol)];
         v[6] = v[0];
         v[7] = v[1];
         v[8] = v[2];
         if (c >= w - 1) begin
            post_edge(grad_eval(v), 1'b1);
            col_cnt = 0;
            row_cnt = 0;
            frames_done++;
            for (int i = 0; i < 3; i++)
               for (int j = 0; j < 3; j++) win[i][j] = '0;
         end else begin
            post_edge(grad_eval(v), 1'b0);
            col_cnt = c + 1;
         end
      end else begin
         // Push after the last row, before the flush: dropped.
         if (r >= h) begin
            ignored_count++;
            return;
         end
         push_count++;
         older = line_mem[line_slot(r, c)];
         prev  = line_mem[line_slot(r - 1, c)];
         line_mem[line_slot(r, c)] = pix;
         for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
         end
         win[0][2] = older;
         win[1][2] = prev;
         win[2][2] = pix;
         if (r >= 1 && c >= 1)
            post_edge((c == 1) ? win_eval(2, 1, 2, r == 1) : win_eval(0, 1, 2, r == 1), 1'b0);
         if (c >= w - 1) begin
            if (r >= 1) post_edge(win_eval(1, 2, 1, r == 1), 1'b0);
            col_cnt = 0;
            row_cnt = (r + 1) & 16'hFFFF;
         end else begin
            col_cnt = c + 1;
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Idle draws and pixel content
   // ---------------------------------------------------------------------------
   function automatic int draw_wait(idle_mode_e mode);
      case (mode)
         IDLE_NONE:  return 0;
         IDLE_LIGHT: return ($urandom_range(3, 0) == 0) ? $urandom_range(17, 0) : 0;
         default:    return $urandom_range(17, 0);
      endcase
   endfunction

   function automatic logic [15:0] pixel_pick(int col, int row);
      case (pix_mode)
         PIX_RAILS: return $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
         PIX_LOW:   return $urandom_range(255, 0);
         PIX_RAMP:  return 16'(col * 1000 + row * 3000 + $urandom_range(63, 0));
         default:   return $urandom_range(65535, 0);
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Driver: present queued items, hold each until it is taken
   // ---------------------------------------------------------------------------
   int gap_count = 0;

   always @(posedge clock) begin
      pix_item_t nxt;
      logic      fire;
      if (reset) begin
         req_valid <= 1'b0;
         gap_count = 0;
      end else begin
         fire = req_valid && !req_stall;
         // Predict from the payload that was just taken.
         if (fire) predict_edges(req_action, req_pixel);
         // Keep a stalled item steady; otherwise advance to the next one.
         if (fire || !req_valid) begin
            if (pixel_queue.size() != 0 && gap_count >= pixel_queue[0].gap) begin
               nxt = pixel_queue.pop_front();
               req_valid  <= 1'b1;
               req_action <= nxt.action;
               req_pixel  <= nxt.pixel;
               gap_count = 0;
            end else begin
               req_valid <= 1'b0;
               if (pixel_queue.size() != 0) gap_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: check each result against the oldest prediction, then stall
   // ---------------------------------------------------------------------------
   int rsp_hold = 0;

   always @(posedge clock) begin
      edge_result_t want;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            result_count++;
            if (pending_edges.size() == 0) begin
               err_count++;
               if (err_count <= REPORT_LIMIT)
                  $display("unexpected result: edge_value %0d frame_last %b",
                           rsp_edge_value, rsp_frame_last);
            end else begin
               want = pending_edges.pop_front();
               if (rsp_edge_value !== want.edge_value || rsp_frame_last !== want.frame_last) begin
                  err_count++;
                  if (err_count <= REPORT_LIMIT)
                     $display("result %0d: expected edge_value %0d frame_last %b, got %0d %b",
                              result_count, want.edge_value, want.frame_last,
                              rsp_edge_value, rsp_frame_last);
               end
            end
            // Draw how long the next result waits.
            rsp_hold = draw_wait(rsp_mode);
         end
         rsp_stall <= (rsp_hold > 0);
         if (rsp_hold > 0) rsp_hold--;
      end
   end

   // ---------------------------------------------------------------------------
   // Watchdog: drop the run when nothing moves for too long
   // ---------------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending_edges.size());
            $display("tb_compass_edge_detector_3x3 failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   task automatic add_item(input logic act, input logic [15:0] pix);
      pix_item_t it;
      it.action = act;
      it.pixel  = pix;
      it.gap    = draw_wait(send_mode);
      pixel_queue.push_back(it);
   endtask

   task automatic add_rows(input int w, input int row_from, input int row_to);
      for (int row = row_from; row < row_to; row++)
         for (int col = 0; col < w; col++) add_item(ACTION_PUSH, pixel_pick(col, row));
   endtask

   task automatic add_flushes(input int w);
      for (int col = 0; col < w; col++) add_item(ACTION_FLUSH, $urandom_range(65535, 0));
   endtask

   // Hold the sender until every queued item is taken and every result is back.
   task automatic wait_drained();
      do @(posedge clock);
      while (pixel_queue.size() != 0 || req_valid || pending_edges.size() != 0);
   endtask

   // Drain, then cover items still in flight that produce no result.
   task automatic settle();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(input logic [2:0] idx, input int value);
      logic [15:0] val;
      val = value[15:0];
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_IMAGE_WIDTH:    cfg_width  = val[12:0];
         CSR_IMAGE_HEIGHT:   cfg_height = val;
         CSR_GRADIENT_SHIFT: cfg_shift  = val[4:0];
         CSR_THRESH_LOW:     cfg_lo     = val;
         CSR_THRESH_HIGH:    cfg_hi     = val;
         CSR_MAX_LEVEL:      cfg_max    = val;
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic set_config(input int w, input int h, input int sh,
                             input int lo, input int hi, input int lvl);
      csr_put(CSR_IMAGE_WIDTH, w);
      csr_put(CSR_IMAGE_HEIGHT, h);
      csr_put(CSR_GRADIENT_SHIFT, sh);
      csr_put(CSR_THRESH_LOW, lo);
      csr_put(CSR_THRESH_HIGH, hi);
      csr_put(CSR_MAX_LEVEL, lvl);
   endtask

   function automatic int pick_level();
      case ($urandom_range(3, 0))
         0:       return 1;
         1:       return 255;
         2:       return 65535;
         default: return $urandom_range(65535, 1);
      endcase
   endfunction

   function automatic int pick_thresh(int lvl);
      case ($urandom_range(4, 0))
         0:       return 0;
         1:       return 65535;
         2:       return $urandom_range(65535, 0);
         default: return $urandom_range(lvl, 0);
      endcase
   endfunction

   function automatic int pick_shift();
      case ($urandom_range(3, 0))
         0:       return 0;
         1:       return 19;
         default: return $urandom_range(19, 0);
      endcase
   endfunction

   // One frame with random geometry, content, thresholds and idling; drop in
   // ignored items now and then, and sometimes start with a tall height that is
   // cut down once all rows of the frame are in.
   task automatic random_frame(input bit force_pause, output int items);
      int  w, h, roll, lvl, lo, hi, sh, split, noise_at;
      bit  tall, pause, noise_mid;
      roll = $urandom_range(19, 0);
      if (roll < 14)      w = $urandom_range(10, 2);
      else if (roll < 19) w = $urandom_range(64, 11);
      else                w = $urandom_range(300, 65);
      h         = $urandom_range(5, 2);
      tall      = ($urandom_range(7, 0) == 0);
      pause     = force_pause || ($urandom_range(4, 0) == 0);
      noise_mid = ($urandom_range(3, 0) == 0);
      split     = $urandom_range(h - 1, 1);
      noise_at  = $urandom_range(h - 1, 1);
      lvl       = pick_level();
      lo        = pick_thresh(lvl);
      hi        = pick_thresh(lvl);
      sh        = pick_shift();
      settle();
      send_mode = idle_mode_e'($urandom_range(2, 0));
      rsp_mode  = idle_mode_e'($urandom_range(2, 0));
      pix_mode  = pix_mode_e'($urandom_range(3, 0));
      set_config(w, tall ? ($urandom_range(1, 0) ? 65535 : $urandom_range(1000, 6)) : h,
                 sh, lo, hi, lvl);
      // An early flush at frame start is dropped.
      if ($urandom_range(3, 0) == 0) add_item(ACTION_FLUSH, $urandom_range(65535, 0));
      for (int row = 0; row < h; row++) begin
         if (pause && row == split) wait_drained();
         if (noise_mid && row == noise_at) add_item(ACTION_FLUSH, $urandom_range(65535, 0));
         add_rows(w, row, row + 1);
      end
      if (tall) begin
         // Cut the height to at most the rows already taken; the flush then uses the
         // two newest rows.
         settle();
         csr_put(CSR_IMAGE_HEIGHT, $urandom_range(h, 2));
      end
      // A push after the last row is dropped.
      if ($urandom_range(3, 0) == 0) add_item(ACTION_PUSH, $urandom_range(65535, 0));
      add_flushes(w);
      items = w * h + w;
   endtask

   // ---------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------
   initial begin
      int random_items, items;
      bit first;
      random_items = 0;
      first = 1'b1;
      for (int i = 0; i < 2*MAX_W; i++) line_mem[i] = '0;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) win[i][j] = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Smallest frame, rail pixels, pass-through thresholds. Open with an
      // early flush and slip a push in after the last row; both are dropped.
      set_config(2, 2, 0, 0, 65535, 65535);
      add_item(ACTION_FLUSH, 16'hFFFF);
      add_item(ACTION_PUSH, 16'hFFFF);
      add_item(ACTION_PUSH, 16'h0000);
      add_item(ACTION_PUSH, 16'h0000);
      add_item(ACTION_PUSH, 16'hFFFF);
      add_item(ACTION_PUSH, 16'h0000);
      add_flushes(2);

      // Lower the width in the middle of the first row: the next push ends it.
      settle();
      send_mode = IDLE_LIGHT;
      rsp_mode  = IDLE_LIGHT;
      set_config(4, 3, 3, 10, 2000, 65535);
      add_rows(4, 0, 0);
      add_item(ACTION_PUSH, 16'h0000);
      add_item(ACTION_PUSH, 16'hFFFF);
      settle();
      csr_put(CSR_IMAGE_WIDTH, 2);
      add_item(ACTION_PUSH, 16'h8001);
      add_rows(2, 1, 3);
      add_flushes(2);

      // Tallest height, then cut to two after three rows. Low threshold above
      // the clamped level turns every pixel that reaches the high one to zero.
      settle();
      pix_mode = PIX_RAILS;
      set_config(2, 65535, 0, 65535, 0, 1000);
      add_rows(2, 0, 3);
      settle();
      csr_put(CSR_IMAGE_HEIGHT, 2);
      add_flushes(2);

      // Widest frame, two rows, no idling so it runs at full rate.
      settle();
      send_mode = IDLE_NONE;
      rsp_mode  = IDLE_NONE;
      pix_mode  = PIX_FULL;
      set_config(MAX_W, 2, 0, 0, 65535, 65535);
      add_rows(MAX_W, 0, 2);
      add_flushes(MAX_W);

      // Random frames; the first one always pauses the sender mid-frame.
      while (random_items < RANDOM_ITEMS) begin
         random_frame(first, items);
         random_items += items;
         first = 1'b0;
      end

      settle();
      $display("covered %0d pixel pushes, %0d flush steps, %0d dropped items, %0d results checked",
               push_count, flush_count, ignored_count, result_count);
      $display("across %0d frames and %0d register writes, %0d failures",
               frames_done, csr_writes, err_count);
      if (err_count == 0 && pending_edges.size() == 0) begin
         $display("tb_compass_edge_detector_3x3 passed");
      end else begin
         $display("tb_compass_edge_detector_3x3 failed");
      end
      $finish;
   end

endmodule
